@@ sv/pyb_pkg.sv @@
// shared types and constants for the point-in-yawed-box tester
// no dependencies; every other file of the block refers to this package by scoped names
`default_nettype none
package pyb_pkg;

    // field widths
    localparam int CW  = 32;          // coordinate width, Q16.16
    localparam int TW  = 16;          // trig width
    localparam int TF  = TW - 2;      // trig fraction bits
    localparam int EW  = CW - 1;      // extent width, unsigned
    localparam int DW  = CW + 1;      // centered offset width
    localparam int PW  = DW + TW;     // offset times trig
    localparam int SW  = PW + 1;      // sum of two products
    localparam int RW  = SW - TF;     // rotated coordinate after floor
    localparam int BW  = RW + 2;      // bound compare width (twice value, negated extent)
    localparam int FW  = CW + 2;      // prune distance compare width
    localparam int CIW = 3;           // config register index width

    localparam logic signed [TW-1:0] COS_RESET = TW'(1) <<< TF;

    typedef enum logic [CIW-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_EXTENT_X = 3'd3,
        CFG_EXTENT_Y = 3'd4,
        CFG_EXTENT_Z = 3'd5,
        CFG_COS_YAW  = 3'd6,
        CFG_SIN_YAW  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic                 new_box;
    } t_in_word;

    typedef struct packed {
        logic inside_res;
        logic pruned;
    } t_out_word;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic [EW-1:0]        extent_x;
        logic [EW-1:0]        extent_y;
        logic [EW-1:0]        extent_z;
        logic signed [TW-1:0] cos_yaw;
        logic signed [TW-1:0] sin_yaw;
    } t_box_cfg;

    // first-inside tracking state
    typedef struct packed {
        logic                 have_first;
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
    } t_track;

    // per-word evaluation result toward the state update
    typedef struct packed {
        logic in_box;
        logic pruned;
        logic capture;
        logic have_next;
    } t_eval;

endpackage
`default_nettype wire

@@ sv/pyb_cfg_regs.sv @@
// box configuration register file: center, extents and yaw trig
// depends on pyb_pkg
`default_nettype none
module pyb_cfg_regs (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [pyb_pkg::CIW-1:0]  i_cfg_idx,
    input  wire logic [pyb_pkg::CW-1:0]   i_cfg_data,
    output pyb_pkg::t_box_cfg             o_cfg
);

    pyb_pkg::t_box_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.center_z <= '0;
            r_cfg.extent_x <= '0;
            r_cfg.extent_y <= '0;
            r_cfg.extent_z <= '0;
            r_cfg.cos_yaw  <= pyb_pkg::COS_RESET;
            r_cfg.sin_yaw  <= '0;
        end else if (i_cfg_we) begin
            unique case (pyb_pkg::t_cfg_idx'(i_cfg_idx))
                pyb_pkg::CFG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                pyb_pkg::CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                pyb_pkg::CFG_CENTER_Z: r_cfg.center_z <= i_cfg_data;
                pyb_pkg::CFG_EXTENT_X: r_cfg.extent_x <= i_cfg_data[pyb_pkg::EW-1:0];
                pyb_pkg::CFG_EXTENT_Y: r_cfg.extent_y <= i_cfg_data[pyb_pkg::EW-1:0];
                pyb_pkg::CFG_EXTENT_Z: r_cfg.extent_z <= i_cfg_data[pyb_pkg::EW-1:0];
                pyb_pkg::CFG_COS_YAW:  r_cfg.cos_yaw  <= i_cfg_data[pyb_pkg::TW-1:0];
                pyb_pkg::CFG_SIN_YAW:  r_cfg.sin_yaw  <= i_cfg_data[pyb_pkg::TW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ sv/pyb_eval.sv @@
// single-pass point test: prune check, centering, yaw rotation with floor, bound compares
// depends on pyb_pkg
`default_nettype none
module pyb_eval (
    input  pyb_pkg::t_in_word  i_word,
    input  pyb_pkg::t_box_cfg  i_cfg,
    input  pyb_pkg::t_track    i_track,
    output pyb_pkg::t_eval     o_eval
);

    logic                          w_have;
    logic signed [pyb_pkg::FW-1:0] w_px, w_py, w_pz;
    logic signed [pyb_pkg::FW-1:0] w_fx, w_fy, w_fz;
    logic signed [pyb_pkg::FW-1:0] w_ex, w_ey, w_ez;
    logic                          w_far;
    logic signed [pyb_pkg::DW-1:0] w_dx, w_dy, w_dz;
    logic signed [pyb_pkg::PW-1:0] w_xc, w_ys, w_yc, w_xs;
    logic signed [pyb_pkg::SW-1:0] w_rx_sum, w_ry_sum;
    logic signed [pyb_pkg::RW-1:0] w_rx, w_ry;
    logic signed [pyb_pkg::BW-1:0] w_tx, w_ty, w_tz;
    logic signed [pyb_pkg::BW-1:0] w_bx, w_by, w_bz;
    logic                          w_in;

    always_comb begin
        // new box clears tracking ahead of this word
        w_have = i_track.have_first && !i_word.new_box;

        // prune distance against first inside point
        w_px = pyb_pkg::FW'(i_word.point_x);
        w_py = pyb_pkg::FW'(i_word.point_y);
        w_pz = pyb_pkg::FW'(i_word.point_z);
        w_fx = pyb_pkg::FW'(i_track.first_x);
        w_fy = pyb_pkg::FW'(i_track.first_y);
        w_fz = pyb_pkg::FW'(i_track.first_z);
        w_ex = pyb_pkg::FW'($signed({1'b0, i_cfg.extent_x}));
        w_ey = pyb_pkg::FW'($signed({1'b0, i_cfg.extent_y}));
        w_ez = pyb_pkg::FW'($signed({1'b0, i_cfg.extent_z}));
        w_far = (w_px > w_fx + w_ex) || (w_px < w_fx - w_ex) ||
                (w_py > w_fy + w_ey) || (w_py < w_fy - w_ey) ||
                (w_pz > w_fz + w_ez) || (w_pz < w_fz - w_ez);

        // centered offsets, exact
        w_dx = pyb_pkg::DW'(i_word.point_x) - pyb_pkg::DW'(i_cfg.center_x);
        w_dy = pyb_pkg::DW'(i_word.point_y) - pyb_pkg::DW'(i_cfg.center_y);
        w_dz = pyb_pkg::DW'(i_word.point_z) - pyb_pkg::DW'(i_cfg.center_z);

        // yaw rotation, floored back to Q16.16
        w_xc = pyb_pkg::PW'(w_dx) * pyb_pkg::PW'(i_cfg.cos_yaw);
        w_ys = pyb_pkg::PW'(w_dy) * pyb_pkg::PW'(i_cfg.sin_yaw);
        w_yc = pyb_pkg::PW'(w_dy) * pyb_pkg::PW'(i_cfg.cos_yaw);
        w_xs = pyb_pkg::PW'(w_dx) * pyb_pkg::PW'(i_cfg.sin_yaw);
        w_rx_sum = pyb_pkg::SW'(w_xc) + pyb_pkg::SW'(w_ys);
        w_ry_sum = pyb_pkg::SW'(w_yc) - pyb_pkg::SW'(w_xs);
        w_rx = pyb_pkg::RW'(w_rx_sum >>> pyb_pkg::TF);
        w_ry = pyb_pkg::RW'(w_ry_sum >>> pyb_pkg::TF);

        // inclusive half-extent test as 2*v against +-extent
        w_tx = pyb_pkg::BW'(w_rx) <<< 1;
        w_ty = pyb_pkg::BW'(w_ry) <<< 1;
        w_tz = pyb_pkg::BW'(w_dz) <<< 1;
        w_bx = pyb_pkg::BW'($signed({1'b0, i_cfg.extent_x}));
        w_by = pyb_pkg::BW'($signed({1'b0, i_cfg.extent_y}));
        w_bz = pyb_pkg::BW'($signed({1'b0, i_cfg.extent_z}));
        w_in = (w_tx <= w_bx) && (w_tx >= -w_bx) &&
               (w_ty <= w_by) && (w_ty >= -w_by) &&
               (w_tz <= w_bz) && (w_tz >= -w_bz);

        o_eval.pruned    = w_have && w_far;
        o_eval.in_box    = !o_eval.pruned && w_in;
        o_eval.capture   = o_eval.in_box && !w_have;
        o_eval.have_next = w_have || o_eval.in_box;
    end

endmodule
`default_nettype wire

@@ sv/point_in_yawed_box_tester_core.sv @@
// top level of the point-in-yawed-box tester: input register, evaluation, result register
// depends on pyb_pkg, pyb_cfg_regs and pyb_eval
`default_nettype none
//
// channel  direction  signals                                  payload
// in       sink       i_in_valid / o_in_ready / i_in_word      point x,y,z and new_box
// out      source     o_out_valid / i_out_ready / o_out_word   inside_res and pruned
// cfg      sink       i_cfg_we / i_cfg_idx / i_cfg_data        one box register per write
//
// one word per cycle sustained if the output is ready; a taken word sits in the
// input register, is evaluated there and moves on to the result register when free
// the rate is set by the single combinational pass (four 33x16 multiplies, adds, compares)
// which also updates the first-inside tracking, so the next word sees it at once
// a stalled output holds the result register; the input register still takes one more word
// synchronous active-low reset clears both valid flags, tracking and config to defaults
//
module point_in_yawed_box_tester_core (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // point words in
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  pyb_pkg::t_in_word             i_in_word,
    // result words out
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output pyb_pkg::t_out_word            o_out_word,
    // config writes
    input  wire logic                     i_cfg_we,
    input  wire logic [pyb_pkg::CIW-1:0]  i_cfg_idx,
    input  wire logic [pyb_pkg::CW-1:0]   i_cfg_data
);

    pyb_pkg::t_box_cfg  w_cfg;
    pyb_pkg::t_eval     w_eval;

    // input stage
    logic               r_in_valid;
    pyb_pkg::t_in_word  r_in;
    // result stage
    logic               r_out_valid;
    pyb_pkg::t_out_word r_out;
    // first-inside tracking
    pyb_pkg::t_track    r_track;

    logic               w_adv;   // input stage word moves into the result stage

    pyb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pyb_eval u_eval (
        .i_word  (r_in),
        .i_cfg   (w_cfg),
        .i_track (r_track),
        .o_eval  (w_eval)
    );

    // result stage frees when empty or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.inside_res <= w_eval.in_box;
            r_out.pruned     <= w_eval.pruned;
        end
    end

    // tracking, updated as each word is evaluated; first point captured on the first hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track.have_first <= 1'b0;
            r_track.first_x    <= '0;
            r_track.first_y    <= '0;
            r_track.first_z    <= '0;
        end else if (w_adv) begin
            r_track.have_first <= w_eval.have_next;
            if (w_eval.capture) begin
                r_track.first_x <= r_in.point_x;
                r_track.first_y <= r_in.point_y;
                r_track.first_z <= r_in.point_z;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // a pruned word is never reported inside
    a_prune_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.pruned && o_out_word.inside_res))
        else $error("pruned word reported inside");

    // after a new box word, tracking equals that word's inside result
    a_new_box_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.new_box) |=> (r_track.have_first == r_out.inside_res))
        else $error("tracking does not follow new box word");

    // tracking drops only on reset or a new box word
    a_track_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_track.have_first) |->
            (!$past(i_rst_n) || $past(w_adv && r_in.new_box)))
        else $error("tracking cleared without new box");

    // pruning needs a first inside point
    a_prune_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_eval.pruned) |-> r_track.have_first)
        else $error("pruned with no first inside point");

endmodule
`default_nettype wire

@@ sim/pyb_inside_check.sv @@
`timescale 1ns / 1ps
// result checker for the point-in-yawed-box tester: predicts inside/pruned for every point word
// taken in, queues it and compares each result word; depends on pyb_pkg only
module pyb_inside_check (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    input  pyb_pkg::t_in_word            i_in_word,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  pyb_pkg::t_out_word           i_out_word,
    input  wire logic                    i_cfg_we,
    input  wire logic [pyb_pkg::CIW-1:0] i_cfg_idx,
    input  wire logic [pyb_pkg::CW-1:0]  i_cfg_data,
    output int                           o_mismatches,
    output int                           o_outstanding
);

    // box registers as written through the config port
    longint ctr_x, ctr_y, ctr_z;
    longint ext_x, ext_y, ext_z;
    longint cos_v, sin_v;

    // first inside point since the last new_box
    bit     have_anchor;
    longint anchor_x, anchor_y, anchor_z;

    pyb_pkg::t_out_word verdict_q[$];
    pyb_pkg::t_out_word want;

    function automatic bit strays(input longint p, input longint a, input longint ext);
        return (p > a + ext) || (p < a - ext);
    endfunction

    function automatic bit within_half(input longint v, input longint ext);
        return (2 * v <= ext) && (2 * v >= -ext);
    endfunction

    function automatic pyb_pkg::t_out_word judge_point(input pyb_pkg::t_in_word w);
        longint             px, py, pz, dx, dy, dz, rx, ry;
        pyb_pkg::t_out_word r;
        px = longint'($signed(w.point_x));
        py = longint'($signed(w.point_y));
        pz = longint'($signed(w.point_z));
        r  = '0;
        if (w.new_box)
            have_anchor = 1'b0;
        if (have_anchor && (strays(px, anchor_x, ext_x) || strays(py, anchor_y, ext_y) ||
                            strays(pz, anchor_z, ext_z))) begin
            r.pruned = 1'b1;
            return r;
        end
        dx = px - ctr_x;
        dy = py - ctr_y;
        dz = pz - ctr_z;
        // exact products, then floor to q16.16
        rx = (dx * cos_v + dy * sin_v) >>> pyb_pkg::TF;
        ry = (dy * cos_v - dx * sin_v) >>> pyb_pkg::TF;
        r.inside_res = within_half(rx, ext_x) && within_half(ry, ext_y) &&
                       within_half(dz, ext_z);
        if (r.inside_res && !have_anchor) begin
            have_anchor = 1'b1;
            anchor_x    = px;
            anchor_y    = py;
            anchor_z    = pz;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctr_x       = 0;
            ctr_y       = 0;
            ctr_z       = 0;
            ext_x       = 0;
            ext_y       = 0;
            ext_z       = 0;
            cos_v       = longint'(pyb_pkg::COS_RESET);
            sin_v       = 0;
            have_anchor = 1'b0;
            anchor_x    = 0;
            anchor_y    = 0;
            anchor_z    = 0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (pyb_pkg::t_cfg_idx'(i_cfg_idx))
                    pyb_pkg::CFG_CENTER_X: ctr_x = longint'($signed(i_cfg_data));
                    pyb_pkg::CFG_CENTER_Y: ctr_y = longint'($signed(i_cfg_data));
                    pyb_pkg::CFG_CENTER_Z: ctr_z = longint'($signed(i_cfg_data));
                    pyb_pkg::CFG_EXTENT_X: ext_x = longint'(i_cfg_data[pyb_pkg::EW-1:0]);
                    pyb_pkg::CFG_EXTENT_Y: ext_y = longint'(i_cfg_data[pyb_pkg::EW-1:0]);
                    pyb_pkg::CFG_EXTENT_Z: ext_z = longint'(i_cfg_data[pyb_pkg::EW-1:0]);
                    pyb_pkg::CFG_COS_YAW:
                        cos_v = longint'($signed(i_cfg_data[pyb_pkg::TW-1:0]));
                    pyb_pkg::CFG_SIN_YAW:
                        sin_v = longint'($signed(i_cfg_data[pyb_pkg::TW-1:0]));
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                verdict_q.push_back(judge_point(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result word with no point word outstanding");
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_word.inside_res !== want.inside_res)
                        report_mismatch($sformatf("inside_res got %b want %b",
                                                  i_out_word.inside_res, want.inside_res));
                    if (i_out_word.pruned !== want.pruned)
                        report_mismatch($sformatf("pruned got %b want %b",
                                                  i_out_word.pruned, want.pruned));
                end
            end
        end
        o_outstanding = verdict_q.size();
    end

endmodule

@@ sim/tb_point_in_yawed_box_tester_core.sv @@
`timescale 1ns / 1ps
// testbench top for point_in_yawed_box_tester_core: clock, reset, point and config stimulus,
// result-side back-pressure and the verdict; depends on pyb_pkg and pyb_inside_check
module tb_point_in_yawed_box_tester_core;

    localparam int ONE_M        = 1 << 16;  // 1.0 in q16.16
    localparam int IDLE_PCT     = 23;       // chance per cycle that a side idles
    localparam int HOLD_CYCLES  = 80;       // long receiver hold-off
    localparam int STALL_LIMIT  = 2000;     // cycles with no word moving before we give up
    localparam int DRAIN_CYCLES = 8;        // spare cycles after the drain, for stray words
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 72;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    pyb_pkg::t_in_word          in_word;
    logic                       out_valid;
    logic                       out_ready;
    pyb_pkg::t_out_word         out_word;
    logic                       cfg_we;
    logic [pyb_pkg::CIW-1:0]    cfg_idx;
    logic [pyb_pkg::CW-1:0]     cfg_data;

    int                         mismatches;
    int                         outstanding;
    int                         hold_left;
    int                         idle_cycles;
    bit                         quiet;      // no idling on either side
    bit                         hold_req;   // ask the receiver for a long hold-off
    pyb_pkg::t_box_cfg          box_now;    // box the block currently holds, used to aim points

    // 4 ns period
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    point_in_yawed_box_tester_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pyb_inside_check u_inside_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_word    (out_word),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // ---------------------------------------------------------------- word builders

    function automatic pyb_pkg::t_in_word make_point(input logic [pyb_pkg::CW-1:0] x,
                                                     input logic [pyb_pkg::CW-1:0] y,
                                                     input logic [pyb_pkg::CW-1:0] z,
                                                     input logic nb);
        pyb_pkg::t_in_word w;
        w.point_x = x;
        w.point_y = y;
        w.point_z = z;
        w.new_box = nb;
        return w;
    endfunction

    function automatic pyb_pkg::t_box_cfg make_box(input logic [pyb_pkg::CW-1:0] cx,
                                                   input logic [pyb_pkg::CW-1:0] cy,
                                                   input logic [pyb_pkg::CW-1:0] cz,
                                                   input logic [pyb_pkg::EW-1:0] ex,
                                                   input logic [pyb_pkg::EW-1:0] ey,
                                                   input logic [pyb_pkg::EW-1:0] ez,
                                                   input logic [pyb_pkg::TW-1:0] c,
                                                   input logic [pyb_pkg::TW-1:0] s);
        pyb_pkg::t_box_cfg b;
        b.center_x = cx;
        b.center_y = cy;
        b.center_z = cz;
        b.extent_x = ex;
        b.extent_y = ey;
        b.extent_z = ez;
        b.cos_yaw  = c;
        b.sin_yaw  = s;
        return b;
    endfunction

    // mostly a few metres, now and then zero or any 31-bit value
    function automatic logic [pyb_pkg::EW-1:0] random_extent();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return pyb_pkg::EW'($urandom);
        return pyb_pkg::EW'($urandom_range(8 * ONE_M));
    endfunction

    function automatic logic [pyb_pkg::CW-1:0] random_center();
        if ($urandom_range(3) == 0)
            return pyb_pkg::CW'($urandom);
        return pyb_pkg::CW'(longint'($urandom_range(40 * ONE_M)) - 20 * ONE_M);
    endfunction

    function automatic pyb_pkg::t_box_cfg random_box();
        pyb_pkg::t_box_cfg b;
        real               ang;
        b.center_x = random_center();
        b.center_y = random_center();
        b.center_z = random_center();
        b.extent_x = random_extent();
        b.extent_y = random_extent();
        b.extent_z = random_extent();
        if ($urandom_range(4) == 0) begin
            // raw trig words, magnitudes past 1.0 included
            b.cos_yaw = pyb_pkg::TW'($urandom);
            b.sin_yaw = pyb_pkg::TW'($urandom);
        end else begin
            ang       = real'($urandom_range(359)) * 3.14159265358979 / 180.0;
            b.cos_yaw = pyb_pkg::TW'($rtoi($cos(ang) * 16384.0));
            b.sin_yaw = pyb_pkg::TW'($rtoi($sin(ang) * 16384.0));
        end
        return b;
    endfunction

    // center plus a uniform offset in [-span, span], wrapping at the coordinate width
    function automatic logic [pyb_pkg::CW-1:0] near(input longint c, input longint span);
        longint off;
        off = longint'($urandom_range(32'(2 * span))) - span;
        return pyb_pkg::CW'(c + off);
    endfunction

    // most points land around the box so inside, outside and prune all show up;
    // the rest are full-range noise
    function automatic pyb_pkg::t_in_word random_point(input pyb_pkg::t_box_cfg b);
        pyb_pkg::t_in_word w;
        longint            span_xy, span_z;
        w.new_box = ($urandom_range(99) < 8);
        if ($urandom_range(99) < 15) begin
            w.point_x = pyb_pkg::CW'($urandom);
            w.point_y = pyb_pkg::CW'($urandom);
            w.point_z = pyb_pkg::CW'($urandom);
        end else begin
            span_xy = (b.extent_x > b.extent_y) ? longint'(b.extent_x) : longint'(b.extent_y);
            span_xy = span_xy + 32'h4000;
            span_z  = longint'(b.extent_z) + 32'h4000;
            if (span_xy > (longint'(1) << 30))
                span_xy = longint'(1) << 30;
            if (span_z > (longint'(1) << 30))
                span_z = longint'(1) << 30;
            w.point_x = near(longint'($signed(b.center_x)), span_xy);
            w.point_y = near(longint'($signed(b.center_y)), span_xy);
            w.point_z = near(longint'($signed(b.center_z)), span_z);
            // hit the centre plane exactly, the only pass for a zero height
            if ($urandom_range(9) == 0)
                w.point_z = b.center_z;
        end
        return w;
    endfunction

    // ---------------------------------------------------------------- drivers

    // entered and left at a falling edge; valid holds until the word is taken
    task automatic push_point(input pyb_pkg::t_in_word w);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic put_reg(input pyb_pkg::t_cfg_idx idx, input logic [pyb_pkg::CW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    // registers only change with nothing in flight; narrow registers get junk above
    // their width so the masking is exercised
    task automatic load_box(input pyb_pkg::t_box_cfg b);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
        put_reg(pyb_pkg::CFG_CENTER_X, b.center_x);
        put_reg(pyb_pkg::CFG_CENTER_Y, b.center_y);
        put_reg(pyb_pkg::CFG_CENTER_Z, b.center_z);
        put_reg(pyb_pkg::CFG_EXTENT_X, {1'($urandom), b.extent_x});
        put_reg(pyb_pkg::CFG_EXTENT_Y, {1'($urandom), b.extent_y});
        put_reg(pyb_pkg::CFG_EXTENT_Z, {1'($urandom), b.extent_z});
        put_reg(pyb_pkg::CFG_COS_YAW,  {16'($urandom), b.cos_yaw});
        put_reg(pyb_pkg::CFG_SIN_YAW,  {16'($urandom), b.sin_yaw});
        cfg_we  <= 1'b0;
        box_now  = b;
    endtask

    // ---------------------------------------------------------------- result side

    // random back-pressure, plus a counted long hold-off on request
    initial begin
        out_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    // a hang shows up as a long run of cycles with no word moving either way
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        box_now  = make_box('0, '0, '0, '0, '0, '0, pyb_pkg::COS_RESET, '0);
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset box: zero extents, so only the centre point passes
        push_point(make_point(0, 0, 0, 1'b0));              // inside, becomes the anchor
        push_point(make_point(1, 0, 0, 1'b0));              // one lsb off a zero extent: pruned
        push_point(make_point(0, 0, 0, 1'b0));              // back on the anchor
        push_point(make_point(0, 0, 1, 1'b1));              // new box, just off the z plane
        push_point(make_point(0, 1, 0, 1'b0));              // no anchor yet, off the y plane

        // unrotated box at (10, -5, 1), extents 4 x 2 x 3: inclusive bounds per axis
        load_box(make_box(10 * ONE_M, -5 * ONE_M, ONE_M, 4 * ONE_M, 2 * ONE_M, 3 * ONE_M,
                          pyb_pkg::COS_RESET, '0));
        push_point(make_point(10 * ONE_M, -5 * ONE_M, ONE_M, 1'b1));
        push_point(make_point(12 * ONE_M, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(12 * ONE_M + 1, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(8 * ONE_M, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(8 * ONE_M - 1, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(10 * ONE_M, -4 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(10 * ONE_M, -6 * ONE_M - 1, ONE_M, 1'b0));
        push_point(make_point(10 * ONE_M, -5 * ONE_M, ONE_M + 32'h18000, 1'b0));
        push_point(make_point(10 * ONE_M, -5 * ONE_M, ONE_M - 32'h18001, 1'b0));
        // prune distance: strictly beyond anchor +- extent
        push_point(make_point(14 * ONE_M + 1, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(6 * ONE_M - 1, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(14 * ONE_M, -5 * ONE_M, ONE_M, 1'b0));
        // new_box clears the anchor before the prune test
        push_point(make_point(14 * ONE_M + 1, -5 * ONE_M, ONE_M, 1'b1));
        push_point(make_point(11 * ONE_M, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(6 * ONE_M, -5 * ONE_M, ONE_M, 1'b0));
        push_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        push_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));

        // extreme centres, full extents and trig words past +-1.0
        load_box(make_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1,
                          16'h8000, 16'h7FFF));
        push_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        push_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        push_point(make_point(0, 0, 0, 1'b0));

        // random boxes; one phase runs without idling, one holds the result side off
        // long enough to back the block up, one drains fully halfway through
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_box(random_box());
            quiet = (ph == 2);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (ph == 3 && i == 10)
                    hold_req = 1'b1;
                if (ph == 4 && i == PHASE_WORDS / 2) begin
                    in_valid <= 1'b0;
                    wait (outstanding == 0);
                    @(negedge clk);
                end
                push_point(random_point(box_now));
            end
        end

        // let the last results out, then a few spare cycles for stray words
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
